>>> rtl/core/qsfm_pkg.sv
// Package for the quasi-static frequency model: sizes, item kinds, reset values.
package qsfm_pkg;
  localparam int unsigned MaxSymbolsDefault = 256;
  localparam int unsigned FreqBitsDefault   = 16;
  localparam int unsigned FirstPeriod       = 8;
  localparam int unsigned RegIdxBits        = 2;
  localparam int unsigned CfgDataBits       = 16;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_SEARCH = 2'd2,
    KIND_INIT   = 2'd3
  } kind_t;

  typedef enum logic [RegIdxBits-1:0] {
    REG_SYMBOL_COUNT    = 2'd0,
    REG_TOTAL_FREQUENCY = 2'd1,
    REG_UPDATE_PERIOD   = 2'd2
  } reg_idx_t;

  localparam logic [8:0]  SymbolCountReset = 9'd256;
  localparam logic [15:0] TotalFreqReset   = 16'd65535;
  localparam logic [15:0] UpdPeriodReset   = 16'd1024;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;
endpackage

>>> rtl/core/qsfm_div.sv
// Iterative restoring divider: one quotient bit per cycle.
module qsfm_div import qsfm_pkg::*; #(
  parameter int unsigned W = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  div_req_t     req,
  output logic         busy,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);
  localparam int unsigned CntBits = $clog2(W + 1);

  logic [W-1:0]       dvs;
  logic [CntBits-1:0] cnt;
  logic [W:0]         trial;

  assign trial = {rem, quot[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= CntBits'(W);
      quot <= req.dividend[W-1:0];
      rem  <= '0;
      dvs  <= req.divisor[W-1:0];
    end else if (busy) begin
      if (trial[W]) begin
        rem  <= {rem[W-2:0], quot[W-1]};
        quot <= {quot[W-2:0], 1'b0};
      end else begin
        rem  <= trial[W-1:0];
        quot <= {quot[W-2:0], 1'b1};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CntBits'(1)) busy <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_cnt_busy: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start |-> cnt != '0) else $error("divider busy with zero count");
  a_start: assert property (@(posedge clk) disable iff (rst)
    req.start |=> busy) else $error("divider did not start");
  a_done: assert property (@(posedge clk) disable iff (rst)
    busy && !req.start && cnt == CntBits'(1) |=> !busy) else $error("divider overran");
`endif
endmodule

>>> rtl/core/quasi_static_frequency_model_top.sv
// Top level of the quasi-static frequency model: tables, sequencer, result register.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | kind, symbol, target_cum
//  out     | out | out_valid/out_ready| found_symbol, symbol_freq, cum_freq, total_freq
//  cfg     | in  | cfg_we             | cfg_idx, cfg_data
//
// A result follows every beat; a search runs one step per halving of the symbol range
// (8 for 256 symbols). An add that ends a period and rebuilds adds a sweep over the
// symbols and a divide; an init first fills the tables over all MAX_SYMBOLS entries.
// After reset in_ready stays low until the first fill and rebuild are done. One item at
// a time: the next beat can be taken in the cycle after the result beat leaves, so
// out_ready stalls add directly to the item time.
module quasi_static_frequency_model_top import qsfm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [7:0]               symbol,
  input  logic [15:0]              target_cum,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [7:0]               found_symbol,
  output logic [15:0]              symbol_freq,
  output logic [15:0]              cum_freq,
  output logic [15:0]              total_freq,
  input  logic                     cfg_we,
  input  logic [RegIdxBits-1:0]    cfg_idx,
  input  logic [CfgDataBits-1:0]   cfg_data
);
  localparam int unsigned MAX_SYMBOLS = MaxSymbolsDefault;
  localparam int unsigned FREQ_BITS   = FreqBitsDefault;
  localparam int unsigned SB = $clog2(MAX_SYMBOLS);
  localparam int unsigned NB = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned F  = FREQ_BITS;

  typedef enum logic [4:0] {
    S_RST, S_I_DIV, S_I_WAIT, S_I_FILL, S_IDLE, S_A_RD, S_A_WR, S_RB_CHK,
    S_RB_RD, S_RB_WR, S_RB_DIV, S_RB_WAIT, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4,
    S_SR_RD, S_SR_CMP, S_OUT
  } state_t;

  state_t state;

  logic [8:0]  reg_n;
  logic [15:0] reg_total, reg_period;

  logic [F-1:0] cnt_mem [MAX_SYMBOLS];
  logic [F-1:0] cum_mem [MAX_SYMBOLS+1];
  logic [F-1:0] cnt_q, cum_q;
  logic [NB-1:0] cum_ra;
  logic [SB-1:0] cnt_ra;

  logic [NB-1:0] act_n;
  logic [15:0]   act_target;
  logic [F-1:0]  incr, adds_left, extra, period;

  logic [NB-1:0] sym, lo, hi, idx;
  logic [15:0]   tgt;
  logic [F-1:0]  acc, half_sum, f_base, cum_s;
  logic [NB-1:0] split;
  logic [F-1:0]  per_next;
  logic          rst_done;

  div_req_t     dreq;
  logic         dbusy;
  logic [31:0]  dq, dr;

  qsfm_div #(.W(32)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .busy(dbusy), .quot(dq), .rem(dr)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_n <= SymbolCountReset; reg_total <= TotalFreqReset; reg_period <= UpdPeriodReset;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_SYMBOL_COUNT:    reg_n <= cfg_data[8:0];
        REG_TOTAL_FREQUENCY: reg_total <= cfg_data;
        REG_UPDATE_PERIOD:   reg_period <= cfg_data;
        default: ;
      endcase
    end
  end

  // Read ports of the two tables, data registered.
  always_ff @(posedge clk) begin
    cum_q <= cum_mem[cum_ra];
    cnt_q <= cnt_mem[cnt_ra];
  end

  // Double the period toward the target, never past it.
  always_comb begin
    per_next = period;
    if (period < act_target) begin
      if ({period, 1'b0} < {1'b0, act_target})
        per_next = {period[F-2:0], 1'b0};
      else
        per_next = act_target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RST;
      out_valid  <= 1'b0;
      rst_done   <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_RST, S_IDLE: begin
          if (state == S_RST || (in_valid && in_ready && kind == KIND_INIT)) begin
            // Latch clamped count and total, then divide total by count.
            logic [NB-1:0] n;
            logic [15:0]   t;
            n = (reg_n < 9'd2) ? NB'(2)
              : ({{(32-9){1'b0}}, reg_n} > MAX_SYMBOLS) ? NB'(MAX_SYMBOLS) : NB'(reg_n);
            t = ({16'd0, reg_total} < 32'(n)) ? 16'(n) : reg_total;
            act_n      <= n;
            act_target <= reg_period;
            incr       <= '0;
            extra      <= '0;
            period     <= F'(FirstPeriod);
            dreq.dividend <= {16'd0, t};
            dreq.divisor  <= 32'(n);
            dreq.start    <= 1'b1;
            sym <= NB'(symbol);
            state <= S_I_DIV;
          end else if (in_valid && in_ready) begin
            sym <= NB'(symbol);
            tgt <= target_cum;
            case (kind)
              KIND_ADD: begin
                if (NB'(symbol) < act_n && {1'b0, symbol} < 9'(MAX_SYMBOLS)) begin
                  cnt_ra <= SB'(symbol);
                  state  <= S_A_RD;
                end else state <= S_RD0;
              end
              KIND_SEARCH: begin
                lo <= '0; hi <= act_n;
                state <= S_SR_RD;
              end
              default: state <= S_RD0;
            endcase
          end
        end
        S_I_DIV: begin
          dreq.start <= 1'b0;
          state <= S_I_WAIT;
        end
        S_I_WAIT: if (!dbusy) begin
          f_base <= F'(dq);
          split  <= act_n - NB'(dr);
          idx    <= '0;
          state  <= S_I_FILL;
        end
        S_I_FILL: begin
          cnt_mem[idx[SB-1:0]] <= (idx < act_n) ? ((idx < split) ? f_base : f_base + 1'b1) : '0;
          cum_mem[idx + 1'b1] <= '0;
          if (idx == NB'(MAX_SYMBOLS - 1)) state <= S_RB_CHK;
          idx <= idx + 1'b1;
        end
        S_A_RD: state <= S_A_WR;
        S_A_WR: begin
          cnt_mem[cnt_ra] <= cnt_q + incr;
          adds_left <= adds_left - 1'b1;
          state <= (adds_left == F'(1)) ? S_RB_CHK : S_RD0;
        end
        S_RB_CHK: begin
          if (extra != '0) begin
            incr <= incr + 1'b1;
            adds_left <= extra;
            extra <= '0;
            state <= S_RD0;
          end else begin
            period <= per_next;
            idx <= '0; acc <= '0; half_sum <= '0;
            cum_mem[0] <= '0;
            cnt_ra <= '0;
            state <= S_RB_RD;
          end
        end
        S_RB_RD: state <= S_RB_WR;
        S_RB_WR: begin
          cum_mem[idx + 1'b1] <= acc + cnt_q;
          acc <= acc + cnt_q;
          cnt_mem[idx[SB-1:0]] <= (cnt_q >> 1) | F'(1);
          half_sum <= half_sum + ((cnt_q >> 1) | F'(1));
          if (idx + 1'b1 == act_n) state <= S_RB_DIV;
          else begin
            idx <= idx + 1'b1;
            cnt_ra <= SB'(idx + 1'b1);
            state <= S_RB_RD;
          end
        end
        S_RB_DIV: begin
          dreq.dividend <= {{(32-F){1'b0}}, acc - half_sum};
          dreq.divisor  <= 32'(period);
          dreq.start <= 1'b1;
          state <= S_RB_WAIT;
        end
        S_RB_WAIT: begin
          if (dreq.start) dreq.start <= 1'b0;
          else if (!dbusy) begin
            incr <= F'(dq);
            extra <= F'(dr);
            adds_left <= period - F'(dr);
            rst_done <= 1'b1;
            // The rebuild after reset has no item waiting for a result.
            state <= rst_done ? S_RD0 : S_IDLE;
          end
        end
        S_SR_RD: begin
          if (lo + 1'b1 < hi) begin
            cum_ra <= NB'(({1'b0, lo} + {1'b0, hi}) >> 1);
            state <= S_SR_CMP;
          end else begin
            sym <= lo;
            state <= S_RD0;
          end
        end
        S_SR_CMP: state <= S_OUT;
        S_OUT: begin
          // Compare against the registered read of the midpoint.
          if ({{(32-16){1'b0}}, tgt} < 32'(cum_q)) hi <= cum_ra;
          else lo <= cum_ra;
          state <= S_SR_RD;
        end
        S_RD0: begin
          cum_ra <= act_n;
          state <= S_RD1;
        end
        S_RD1: begin
          cum_ra <= (sym < act_n) ? sym : act_n;
          state <= S_RD2;
        end
        S_RD2: begin
          total_freq <= 16'(cum_q);
          cum_ra <= (sym < act_n) ? sym + 1'b1 : act_n;
          state <= S_RD3;
        end
        S_RD3: begin
          cum_s <= cum_q;
          found_symbol <= 8'(sym);
          cum_freq <= 16'(cum_q);
          state <= S_RD4;
        end
        S_RD4: begin
          symbol_freq <= 16'(cum_q - cum_s);
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_search_bounds: assert property (@(posedge clk) disable iff (rst)
    state == S_SR_RD |-> lo < hi) else $error("search window empty");
`endif
endmodule
